/* src/fpa_pkg.sv */
package fpa_pkg;

    localparam int unsigned KIND_W = 4;
    localparam int unsigned WORD_W = 32;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_GE       = 4'd5,
        OP_LT       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } t_op;

endpackage

/* src/fixed_point_alu.sv */
// Signed fixed-point ALU on 32-bit raw words with FRACTION_BITS fraction bits.
// Input channel (s_axis): tuser carries the operation code, tdata the two
// operands. Output channel (m_axis): tdata carries the result word, tuser the
// comparison outcome and the divide-by-zero flag.
// Every operation passes through the same pipeline, so results leave in the
// order their operands arrived. The input transfer is registered, then passes
// through the divider stages and the output register. Throughput is one
// transfer per cycle while the receiver does not stall; the depth is set by the
// restoring divider, which resolves one quotient bit per stage over
// 32 + FRACTION_BITS stages, followed by a rounding and sign stage.
// The multiplier forms the full 64-bit product in the first stage.
// Reset clears all valid bits; nothing is in flight afterwards.
// When the receiver stalls with a valid result, the whole pipeline holds and
// s_axis_tready drops; nothing is lost or repeated, and a new input is
// accepted in the same cycle the waiting result is taken.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] operand_a, [63:32] operand_b
    input  logic [63:0] s_axis_tdata,
    // [3:0] kind
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] value_out
    output logic [31:0] m_axis_tdata,
    // [0] truth, [1] divide_by_zero
    output logic [1:0]  m_axis_tuser
);

    localparam int unsigned NQ = WORD_W + FRACTION_BITS;
    localparam int unsigned RW = WORD_W + 1;

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [WORD_W-1:0] a, b;
    logic [WORD_W-1:0]        ua, ub, ma, mb;
    logic signed [2*WORD_W-1:0] prod;
    t_op                      op;
    logic [WORD_W-1:0]        n_res;
    logic                     n_truth;

    assign a    = s_axis_tdata[WORD_W-1:0];
    assign b    = s_axis_tdata[2*WORD_W-1:WORD_W];
    assign ua   = s_axis_tdata[WORD_W-1:0];
    assign ub   = s_axis_tdata[2*WORD_W-1:WORD_W];
    assign op   = t_op'(s_axis_tuser);
    assign ma   = a[WORD_W-1] ? (~ua + 1'b1) : ua;
    assign mb   = b[WORD_W-1] ? (~ub + 1'b1) : ub;
    assign prod = a * b;

    always_comb begin
        n_res   = '0;
        n_truth = 1'b0;
        unique case (op)
            OP_ADD:      n_res = ua + ub;
            OP_SUB:      n_res = ua - ub;
            OP_MUL:      n_res = prod[FRACTION_BITS+WORD_W-1:FRACTION_BITS];
            OP_DIV:      n_res = '0;
            OP_GT:       n_truth = a > b;
            OP_GE:       n_truth = a >= b;
            OP_LT:       n_truth = a < b;
            OP_LE:       n_truth = a <= b;
            OP_EQ:       n_truth = a == b;
            OP_NE:       n_truth = a != b;
            OP_MIN:      n_res = (a <= b) ? ua : ub;
            OP_MAX:      n_res = (a >= b) ? ua : ub;
            OP_INC:      n_res = ua + 1'b1;
            OP_DEC:      n_res = ua - 1'b1;
            OP_FROM_INT: n_res = ua << FRACTION_BITS;
            OP_TO_INT:   n_res = WORD_W'(a >>> FRACTION_BITS);
            default:     n_res = '0;
        endcase
    end

    logic              r_vld   [0:NQ];
    logic              r_div   [0:NQ];
    logic              r_neg   [0:NQ];
    logic              r_dz    [0:NQ];
    logic              r_truth [0:NQ];
    logic [WORD_W-1:0] r_res   [0:NQ];
    logic [WORD_W-1:0] r_mb    [0:NQ];
    logic [RW-1:0]     r_rem   [0:NQ];
    logic [NQ-1:0]     r_qn    [0:NQ];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
        end
        if (en) begin
            r_div[0]   <= (op == OP_DIV);
            r_neg[0]   <= a[WORD_W-1] ^ b[WORD_W-1];
            r_dz[0]    <= (op == OP_DIV) && (ub == '0);
            r_truth[0] <= n_truth;
            r_res[0]   <= n_res;
            r_mb[0]    <= mb;
            r_rem[0]   <= '0;
            r_qn[0]    <= {ma, {FRACTION_BITS{1'b0}}};
        end
    end

    for (genvar k = 0; k < NQ; k++) begin : g_div
        logic [RW-1:0] n_trial;
        logic          n_fit;
        assign n_trial = {r_rem[k][RW-2:0], r_qn[k][NQ-1]};
        assign n_fit   = n_trial >= {1'b0, r_mb[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (en) begin
                r_div[k+1]   <= r_div[k];
                r_neg[k+1]   <= r_neg[k];
                r_dz[k+1]    <= r_dz[k];
                r_truth[k+1] <= r_truth[k];
                r_res[k+1]   <= r_res[k];
                r_mb[k+1]    <= r_mb[k];
                r_rem[k+1]   <= n_fit ? (n_trial - {1'b0, r_mb[k]}) : n_trial;
                r_qn[k+1]    <= {r_qn[k][NQ-2:0], n_fit};
            end
        end
    end

    logic              n_up;
    logic [WORD_W-1:0] n_quot;
    logic [WORD_W-1:0] n_out;

    // The negated rounded quotient is ~q + 1 - up, so one adder covers both signs.
    always_comb begin
        n_up   = {r_rem[NQ], 1'b0} >= {2'b00, r_mb[NQ]};
        n_quot = (r_neg[NQ] ? ~r_qn[NQ][WORD_W-1:0] : r_qn[NQ][WORD_W-1:0])
                 + {{(WORD_W-1){1'b0}}, r_neg[NQ] ^ n_up};
        if (r_dz[NQ]) begin
            n_out = '0;
        end else if (r_div[NQ]) begin
            n_out = n_quot;
        end else begin
            n_out = r_res[NQ];
        end
    end

    logic              r_out_vld;
    logic [WORD_W-1:0] r_out;
    logic              r_out_truth;
    logic              r_out_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[NQ];
        end
        if (en) begin
            r_out       <= n_out;
            r_out_truth <= r_truth[NQ];
            r_out_dz    <= r_dz[NQ];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = {r_out_dz, r_out_truth};

endmodule

/* src/fpa_checker.sv */
module fpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A result is never both a comparison and a failed division.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'b11)
        else $error("truth and divide_by_zero both set");

    // A division by zero always yields a zero word.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 32'd0)
        else $error("divide by zero with nonzero result");

    // The input side is stalled exactly when a result waits.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import fpa_pkg::*;

    localparam int FRAC = 8;
    localparam int LATENCY = FRAC + 33;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_OPS = 800;

    typedef struct packed {
        logic [31:0] value;
        logic        truth;
        logic        div_zero;
    } t_alu_result;

    function automatic t_alu_result compute_alu(t_op op, logic [31:0] a, logic [31:0] b);
        t_alu_result r;
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic signed [63:0] prod;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rem;
        r = '0;
        sa = {{32{a[31]}}, a};
        sb = {{32{b[31]}}, b};
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: begin
                prod = sa * sb;
                prod = prod >>> FRAC;
                r.value = prod[31:0];
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.div_zero = 1'b1;
                end else begin
                    ma = sa < 0 ? -sa : sa;
                    mb = sb < 0 ? -sb : sb;
                    num = ma << FRAC;
                    q = num / mb;
                    rem = num % mb;
                    if (2 * rem >= mb) q = q + 1;
                    if ((sa < 0) != (sb < 0)) q = -q;
                    r.value = q[31:0];
                end
            end
            OP_GT: r.truth = sa > sb;
            OP_GE: r.truth = sa >= sb;
            OP_LT: r.truth = sa < sb;
            OP_LE: r.truth = sa <= sb;
            OP_EQ: r.truth = sa == sb;
            OP_NE: r.truth = sa != sb;
            OP_MIN: r.value = (sa <= sb) ? a : b;
            OP_MAX: r.value = (sa >= sb) ? a : b;
            OP_INC: r.value = a + 1;
            OP_DEC: r.value = a - 1;
            OP_FROM_INT: r.value = a << FRAC;
            default: begin
                prod = sa >>> FRAC;
                r.value = prod[31:0];
            end
        endcase
        return r;
    endfunction

    class t_alu_scoreboard;
        t_alu_result pending[$];
        int mismatches = 0;

        function void note_operation(t_op op, logic [31:0] a, logic [31:0] b);
            pending.push_back(compute_alu(op, a, b));
        endfunction

        function void check_result(logic [31:0] value, logic [1:0] flags);
            t_alu_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h flags %b", value, flags);
                return;
            end
            want = pending.pop_front();
            if (want.value !== value || want.truth !== flags[0] || want.div_zero !== flags[1]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %h t%b dz%b, got %h t%b dz%b",
                             want.value, want.truth, want.div_zero, value, flags[0], flags[1]);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    t_alu_scoreboard results = new();
    int idle_cycles = 0;
    int stall_mode = 0;

    fixed_point_alu #(.FRACTION_BITS(FRAC)) uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) results.check_result(m_axis_tdata, m_axis_tuser);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 3) != 0;
                2: m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= $urandom_range(0, 7) == 0;
            endcase
        end
    end

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 1024)) - 512);
            3: return 32'h0000_0100 * ($urandom_range(0, 32) - 16);
            4: return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_operation(t_op op, logic [31:0] a, logic [31:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {b, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        results.note_operation(op, a, b);
    endtask

    task automatic pause_sender(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        int burst;
        int sent;
        int settle;
        @(posedge i_rst_n);
        @(posedge i_clk);
        for (int op = 0; op < 16; op++) begin
            send_operation(t_op'(op), 32'h7fff_ffff, 32'h8000_0000);
            send_operation(t_op'(op), 32'h0000_0300, 32'h0000_0300);
        end
        send_operation(OP_DIV, 32'h0000_0100, 32'h0);
        send_operation(OP_DIV, 32'h8000_0000, 32'h0000_0100);
        send_operation(OP_DIV, 32'h0000_0001, 32'h0000_0200);
        send_operation(OP_DIV, 32'hffff_ffff, 32'h0000_0200);
        send_operation(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_operation(OP_TO_INT, 32'hffff_ff01, 32'h0);
        pause_sender(1);
        while (results.pending.size() != 0) @(posedge i_clk);
        sent = 0;
        while (sent < RANDOM_OPS) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_OPS; k++) begin
                send_operation(t_op'($urandom_range(0, 15)), random_operand(), random_operand());
                sent++;
            end
            if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 12));
        end
        pause_sender(1);
        settle = 0;
        while (results.pending.size() != 0 && settle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (results.mismatches == 0 && results.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

/* fixed_point_alu.f */
src/fpa_pkg.sv
src/fixed_point_alu.sv
src/fpa_checker.sv
tb/testbench.sv
